// ----- rtl/core/amtg_pkg.sv -----
// Shared types, constants and helpers for the accented metronome tone generator.
package amtg_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 256;
    localparam int unsigned ADDR_MAX_W      = 12;   // enough for the largest table depth

    localparam int unsigned TICK_W    = 20;
    localparam int unsigned PASSES_W  = 16;
    localparam int unsigned PASS_W    = 18;
    localparam int unsigned PTR_W     = 9;
    localparam int unsigned BEAT_W    = 2;
    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned INDEX_W   = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 20;

    localparam logic [BEAT_W-1:0] ACCENT_BEAT = 2'd3;
    localparam logic [PTR_W:0]    STEP_NORMAL = 10'd1;
    localparam logic [PTR_W:0]    STEP_ACCENT = 10'd2;

    localparam logic [TICK_W-1:0]   BEAT_PERIOD_RST  = 20'd8000;
    localparam logic [PASSES_W-1:0] BURST_PASSES_RST = 16'd1;
    localparam logic [PTR_W-1:0]    WAVE_LENGTH_RST  = 9'd256;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BEAT_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_PASSES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_LENGTH  = 2'd2;

    localparam logic ACTION_TICK = 1'b0;
    localparam logic ACTION_LOAD = 1'b1;

    typedef struct packed {
        logic                        action;
        logic [INDEX_W-1:0]          table_index;
        logic signed [SAMPLE_W-1:0]  table_value;
    } amtg_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]  sample;
        logic [BEAT_W-1:0]           beat_number;
        logic                        burst_active;
    } amtg_out_t;

    // Sequencer status after one tick
    typedef struct packed {
        logic                active;
        logic [BEAT_W-1:0]   beat;
    } amtg_status_t;

    // Reduce a narrow index modulo a constant table depth by compare and subtract
    function automatic logic [ADDR_MAX_W-1:0] wrap_index(input logic [PTR_W-1:0] x,
                                                         input int unsigned depth);
        int unsigned r;
        r = 32'(x);
        for (int k = PTR_W - 1; k >= 0; k--) begin
            if (r >= (depth << k)) begin
                r = r - (depth << k);
            end
        end
        return ADDR_MAX_W'(r);
    endfunction

endpackage

// ----- rtl/core/accented_metronome_tone_generator.sv -----
// Top level of the accented metronome tone generator: table memory, pipeline, config.
//
// Usage: each tick transaction on the s_ channel (action = tick) yields one
// audio sample on the m_ channel; a load transaction (action = load) writes one
// waveform table entry and yields nothing. Every beat_period ticks a burst
// starts and replays the table burst_passes times; every fourth beat plays the
// table at double step for four times as many passes.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write only while no tick transaction is in flight.
// Pipeline: a tick's sequencer update and table read are registered in the read
// stage, then the output register presents the sample on m_valid/m_data.
// Throughput: one transaction per cycle while the output is not stalled, set by
// the sequencer update and the one registered table read port.
// Reset: aresetn (synchronous, active low) clears all counters and restores the
// register defaults; the table is not cleared and must be loaded before use.
// Stall: when m_ready is low the output register holds, one more tick is
// buffered in the read stage, then s_ready drops until the output drains.
module accented_metronome_tone_generator #(
    parameter int unsigned TABLE_DEPTH = amtg_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  amtg_pkg::amtg_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output amtg_pkg::amtg_out_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [amtg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [amtg_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import amtg_pkg::*;

    localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);

    logic [TICK_W-1:0]   beat_period_reg;
    logic [PASSES_W-1:0] burst_passes_reg;
    logic [PTR_W-1:0]    wave_length_reg;

    logic signed [SAMPLE_W-1:0] wave_mem [TABLE_DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    logic              s1_valid_reg, s1_valid_next;
    amtg_status_t      s1_status_reg;
    logic              m_valid_reg, m_valid_next;
    amtg_out_t         m_data_reg, m_data_next;

    logic              s_accept;
    logic              tick_en;
    logic              load_en;
    logic              s1_move;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_MAX_W-1:0] wr_full;
    amtg_status_t      tick_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_period_reg  <= BEAT_PERIOD_RST;
            burst_passes_reg <= BURST_PASSES_RST;
            wave_length_reg  <= WAVE_LENGTH_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BEAT_PERIOD:  beat_period_reg  <= cfg_data;
                CFG_BURST_PASSES: burst_passes_reg <= cfg_data[PASSES_W-1:0];
                CFG_WAVE_LENGTH:  wave_length_reg  <= cfg_data[PTR_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the read stage moves on when the output register is free or taken
    assign s1_move  = !m_valid_reg || m_ready;
    assign s_ready  = !s1_valid_reg || s1_move;
    assign s_accept = s_valid && s_ready;
    assign tick_en  = s_accept && (s_data.action == ACTION_TICK);
    assign load_en  = s_accept && (s_data.action == ACTION_LOAD);

    amtg_beat_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_beat_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick_en      (tick_en),
        .beat_period  (beat_period_reg),
        .burst_passes (burst_passes_reg),
        .wave_length  (wave_length_reg),
        .rd_addr      (rd_addr),
        .status       (tick_status)
    );

    assign wr_full = wrap_index({1'b0, s_data.table_index}, TABLE_DEPTH);
    assign wr_addr = wr_full[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (load_en) begin
            wave_mem[wr_addr] <= s_data.table_value;
        end
        if (tick_en) begin
            rd_data_reg <= wave_mem[rd_addr];
        end
    end

    always_comb begin
        if (tick_en) begin
            s1_valid_next = 1'b1;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end

        m_valid_next = s1_move ? s1_valid_reg : m_valid_reg;

        m_data_next = m_data_reg;
        if (s1_move && s1_valid_reg) begin
            // Silence the sample once the burst is over
            m_data_next.sample       = s1_status_reg.active ? rd_data_reg : '0;
            m_data_next.beat_number  = s1_status_reg.beat;
            m_data_next.burst_active = s1_status_reg.active;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_en) begin
            s1_status_reg <= tick_status;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- rtl/core/amtg_beat_ctrl.sv -----
// Beat sequencer: sample, beat, pass and table pointer counters with read address.
module amtg_beat_ctrl #(
    parameter int unsigned TABLE_DEPTH = amtg_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned ADDR_W      = $clog2(TABLE_DEPTH)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              tick_en,
    input  logic [amtg_pkg::TICK_W-1:0]       beat_period,
    input  logic [amtg_pkg::PASSES_W-1:0]     burst_passes,
    input  logic [amtg_pkg::PTR_W-1:0]        wave_length,
    output logic [ADDR_W-1:0]                 rd_addr,
    output amtg_pkg::amtg_status_t            status
);
    import amtg_pkg::*;

    logic [TICK_W-1:0] tick_count_reg, tick_count_next;
    logic [PASS_W-1:0] pass_count_reg, pass_count_next;
    logic [PTR_W-1:0]  table_ptr_reg, table_ptr_next;
    logic [BEAT_W-1:0] beat_reg, beat_next;
    logic              active_reg, active_next;

    logic              beat_start;
    logic              accent;
    logic [PTR_W-1:0]  ptr_start;
    logic [PASS_W-1:0] pass_start;
    logic              active_start;
    logic [PTR_W:0]    ptr_sum;
    logic              ptr_wrap;
    logic [PTR_W-1:0]  ptr_step;
    logic [PASS_W-1:0] pass_step;
    logic [PASS_W-1:0] pass_limit;
    logic              burst_done;
    logic [TICK_W:0]   tick_sum;
    logic              tick_wrap;
    logic [ADDR_MAX_W-1:0] addr_full;

    always_comb begin
        beat_start   = (tick_count_reg == '0);
        ptr_start    = beat_start ? '0 : table_ptr_reg;
        pass_start   = beat_start ? '0 : pass_count_reg;
        active_start = beat_start | active_reg;
        accent       = (beat_reg == ACCENT_BEAT);

        ptr_sum   = {1'b0, ptr_start} + (accent ? STEP_ACCENT : STEP_NORMAL);
        ptr_wrap  = (ptr_sum >= {1'b0, wave_length});
        ptr_step  = ptr_wrap ? '0 : ptr_sum[PTR_W-1:0];
        pass_step = ptr_wrap ? pass_start + PASS_W'(1) : pass_start;

        pass_limit = accent ? {burst_passes, 2'b00} : {2'b00, burst_passes};
        burst_done = (pass_step >= pass_limit);

        // Drop the burst once the pass limit is hit
        if (active_start && !burst_done) begin
            active_next     = 1'b1;
            table_ptr_next  = ptr_step;
            pass_count_next = pass_step;
        end else if (active_start) begin
            active_next     = 1'b0;
            table_ptr_next  = '0;
            pass_count_next = '0;
        end else begin
            active_next     = 1'b0;
            table_ptr_next  = ptr_start;
            pass_count_next = pass_start;
        end

        tick_sum  = {1'b0, tick_count_reg} + (TICK_W+1)'(1);
        tick_wrap = (tick_sum >= {1'b0, beat_period});
        tick_count_next = tick_wrap ? '0 : tick_sum[TICK_W-1:0];
        if (tick_wrap) begin
            beat_next = (beat_reg == ACCENT_BEAT) ? '0 : beat_reg + BEAT_W'(1);
        end else begin
            beat_next = beat_reg;
        end

        addr_full = wrap_index(ptr_start, TABLE_DEPTH);
        rd_addr   = addr_full[ADDR_W-1:0];

        status.active = active_next;
        status.beat   = beat_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg <= '0;
            pass_count_reg <= '0;
            table_ptr_reg  <= '0;
            beat_reg       <= '0;
            active_reg     <= 1'b0;
        end else if (tick_en) begin
            tick_count_reg <= tick_count_next;
            pass_count_reg <= pass_count_next;
            table_ptr_reg  <= table_ptr_next;
            beat_reg       <= beat_next;
            active_reg     <= active_next;
        end
    end

endmodule
